// ----- hdl/k2l_pkg.sv -----
// shared types, codes and spelling table for the kannada to latin transliterator
package k2l_pkg;

  // item kinds carried on the input tuser
  typedef enum logic [2:0] {
    OP_LETTER  = 3'd0,
    OP_SPACE   = 3'd1,
    OP_NEWLINE = 3'd2,
    OP_COMMA   = 3'd3,
    OP_EXCLAIM = 3'd4,
    OP_END     = 3'd5
  } op_e;

  localparam int unsigned CharW   = 7;
  localparam int unsigned MaxChar = 4;

  // code ranges
  localparam logic [7:0] ConsFirst  = 8'd149;
  localparam logic [7:0] ConsLast   = 8'd185;
  localparam logic [7:0] Anusvara   = 8'd130;
  localparam logic [7:0] Visarga    = 8'd131;
  localparam logic [7:0] VowelFirst = 8'd133;
  localparam logic [7:0] VowelLast  = 8'd148;

  // ascii characters
  localparam logic [CharW-1:0] ChA       = 7'h61;
  localparam logic [CharW-1:0] ChSpace   = 7'h20;
  localparam logic [CharW-1:0] ChNewline = 7'h0A;
  localparam logic [CharW-1:0] ChComma   = 7'h2C;
  localparam logic [CharW-1:0] ChExclaim = 7'h21;

  // spelling of one code: up to three characters, first in ch[0]
  typedef struct packed {
    logic [1:0]                  len;
    logic [2:0][CharW-1:0]       ch;
  } spell_t;

  function automatic spell_t s1(input logic [7:0] s);
    spell_t r;
    r.len   = 2'd1;
    r.ch[0] = s[6:0];
    r.ch[1] = '0;
    r.ch[2] = '0;
    return r;
  endfunction

  function automatic spell_t s2(input logic [15:0] s);
    spell_t r;
    r.len   = 2'd2;
    r.ch[0] = s[14:8];
    r.ch[1] = s[6:0];
    r.ch[2] = '0;
    return r;
  endfunction

  function automatic spell_t s3(input logic [23:0] s);
    spell_t r;
    r.len   = 2'd3;
    r.ch[0] = s[22:16];
    r.ch[1] = s[14:8];
    r.ch[2] = s[6:0];
    return r;
  endfunction

  // latin spelling of a code byte, empty for unmapped codes
  function automatic spell_t spelling(input logic [7:0] code);
    spell_t r;
    r = '0;
    case (code)
      8'd130: r = s1("n");
      8'd131: r = s1("h");
      8'd133: r = s1("a");
      8'd134: r = s2("aa");
      8'd135: r = s1("i");
      8'd136: r = s2("ii");
      8'd137: r = s1("u");
      8'd138: r = s2("uu");
      8'd139: r = s2("ru");
      8'd142: r = s1("e");
      8'd143: r = s2("ee");
      8'd144: r = s2("ai");
      8'd146: r = s1("o");
      8'd147: r = s2("oo");
      8'd148: r = s2("au");
      8'd149: r = s1("k");
      8'd150: r = s2("kh");
      8'd151: r = s1("g");
      8'd152: r = s2("gh");
      8'd153: r = s2("ng");
      8'd154: r = s2("ch");
      8'd155: r = s3("chh");
      8'd156: r = s1("j");
      8'd157: r = s2("jh");
      8'd158: r = s2("ny");
      8'd159: r = s1("T");
      8'd160: r = s2("Th");
      8'd161: r = s1("D");
      8'd162: r = s2("Dh");
      8'd163: r = s1("N");
      8'd164: r = s1("t");
      8'd165: r = s2("th");
      8'd166: r = s1("d");
      8'd167: r = s2("dh");
      8'd168: r = s1("n");
      8'd170: r = s1("p");
      8'd171: r = s2("ph");
      8'd172: r = s1("b");
      8'd173: r = s2("bh");
      8'd174: r = s1("m");
      8'd175: r = s1("y");
      8'd176: r = s1("r");
      8'd177: r = s1("R");
      8'd178: r = s1("l");
      8'd179: r = s1("L");
      8'd181: r = s1("v");
      8'd182: r = s2("sh");
      8'd183: r = s2("SH");
      8'd184: r = s1("s");
      8'd185: r = s1("h");
      8'd190: r = s2("aa");
      8'd191: r = s1("i");
      8'd192: r = s2("ii");
      8'd193: r = s1("u");
      8'd194: r = s2("uu");
      8'd195: r = s2("ru");
      8'd196: r = s3("rru");
      8'd198: r = s1("e");
      8'd199: r = s2("ee");
      8'd200: r = s2("ai");
      8'd202: r = s1("o");
      8'd203: r = s2("oo");
      8'd204: r = s2("au");
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ----- hdl/kannada_to_latin_transliterator.sv -----
// kannada to latin transliterator: input register, spelling lookup, character serializer
//
//   channel  | dir | tdata (low bit up)        | tuser      | tlast
//   s_axis   | in  | code_low[7:0]             | opcode[2:0]| -
//   m_axis   | out | char_code[6:0], zero pad  | -          | last_of_run
//
// an item causes one to four characters or none, which the single
// character output sends one after another.
// the next item is taken while the current word is still being sent.
// reset clears the pending inherent vowel and all valid flags.
// a stalled output holds the current character and, once the input
// register is full, holds off the input.
module kannada_to_latin_transliterator
  import k2l_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // code_low[7:0]
  input  logic [2:0] s_axis_tuser,   // opcode[2:0]
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // char_code[6:0], bit 7 zero
  output logic       m_axis_tlast    // last_of_run
);

  // input register
  logic       in_valid_q;
  logic [2:0] in_op_q;
  logic [7:0] in_code_q;

  // pending inherent vowel
  logic pend_q, pend_d;

  // word register being serialized
  logic                          w_valid_q;
  logic [MaxChar-1:0][CharW-1:0] w_ch_q, w_ch_d;
  logic [2:0]                    w_cnt_q, w_cnt_d;
  logic [1:0]                    w_idx_q;

  logic   is_cons, keeps_a, put_a;
  spell_t word;
  logic   w_last, m_fire, drain, in_adv, s_fire;

  // classify the registered item and look up its letters
  always_comb begin
    is_cons = 1'b0;
    keeps_a = 1'b0;
    word    = '0;
    case (in_op_q)
      OP_LETTER: begin
        is_cons = (in_code_q >= ConsFirst) && (in_code_q <= ConsLast);
        keeps_a = is_cons || (in_code_q == Anusvara) || (in_code_q == Visarga) ||
                  ((in_code_q >= VowelFirst) && (in_code_q <= VowelLast));
        word    = spelling(in_code_q);
      end
      OP_SPACE: begin
        keeps_a = 1'b1;
        word    = s1({1'b0, ChSpace});
      end
      OP_NEWLINE: begin
        keeps_a = 1'b1;
        word    = s1({1'b0, ChNewline});
      end
      OP_COMMA: begin
        keeps_a = 1'b1;
        word    = s1({1'b0, ChComma});
      end
      OP_EXCLAIM: begin
        keeps_a = 1'b1;
        word    = s1({1'b0, ChExclaim});
      end
      OP_END: begin
        keeps_a = 1'b1;
      end
      default: begin
        keeps_a = 1'b0;
      end
    endcase
    put_a = pend_q && keeps_a;
    pend_d = is_cons;
  end

  // place the optional 'a' ahead of the letters
  always_comb begin
    if (put_a) begin
      w_ch_d[0] = ChA;
      w_ch_d[1] = word.ch[0];
      w_ch_d[2] = word.ch[1];
      w_ch_d[3] = word.ch[2];
    end else begin
      w_ch_d[0] = word.ch[0];
      w_ch_d[1] = word.ch[1];
      w_ch_d[2] = word.ch[2];
      w_ch_d[3] = '0;
    end
    w_cnt_d = {1'b0, word.len} + {2'b00, put_a};
  end

  // handshake control
  assign w_last        = ({1'b0, w_idx_q} == (w_cnt_q - 3'd1));
  assign m_fire        = w_valid_q && m_axis_tready;
  assign drain         = !w_valid_q || (m_fire && w_last);
  assign in_adv        = in_valid_q && drain;
  assign s_axis_tready = !in_valid_q || in_adv;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  // output drive
  assign m_axis_tvalid = w_valid_q;
  assign m_axis_tdata  = {1'b0, w_ch_q[w_idx_q]};
  assign m_axis_tlast  = w_last;

  // input register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_fire) begin
      in_valid_q <= 1'b1;
    end else if (in_adv) begin
      in_valid_q <= 1'b0;
    end
  end

  // input payload
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      in_op_q   <= s_axis_tuser;
      in_code_q <= s_axis_tdata;
    end
  end

  // pending vowel and word control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q    <= 1'b0;
      w_valid_q <= 1'b0;
      w_idx_q   <= 2'd0;
    end else begin
      if (in_adv) begin
        pend_q    <= pend_d;
        w_valid_q <= (w_cnt_d != 3'd0);
        w_idx_q   <= 2'd0;
      end else if (m_fire && w_last) begin
        w_valid_q <= 1'b0;
      end else if (m_fire) begin
        w_idx_q <= w_idx_q + 2'd1;
      end
    end
  end

  // word payload
  always_ff @(posedge clk_i) begin
    if (in_adv) begin
      w_ch_q  <= w_ch_d;
      w_cnt_q <= w_cnt_d;
    end
  end

endmodule
